[rtl/ray_disk_intersection_defines.svh]
// Assertion macros shared by the ray against disk intersection RTL.
// Include this file by its bare name; it depends on nothing else.
`ifndef RAY_DISK_INTERSECTION_DEFINES_SVH
`define RAY_DISK_INTERSECTION_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RDI_ASSERT_IMPL(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ray disk check failed");

// Next-cycle implication, checked outside reset.
`define RDI_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ray disk check failed");

`endif

[rtl/rdi_pkg.sv]
// Shared types and constants for the ray against disk intersection block.
// No dependencies; rdi_div and ray_disk_intersection refer to this package by scope.
package rdi_pkg;

	// Fixed-point and datapath widths.
	localparam int FRAC_BITS = 16;
	localparam int QUO_W     = 31;
	localparam int MAG_W     = 52;
	localparam int SUM_W     = 53;
	localparam int IDX_W     = 3;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_CENTER_X    = 3'd0;
	localparam logic [IDX_W-1:0] REG_CENTER_Y    = 3'd1;
	localparam logic [IDX_W-1:0] REG_CENTER_Z    = 3'd2;
	localparam logic [IDX_W-1:0] REG_NORMAL_X    = 3'd3;
	localparam logic [IDX_W-1:0] REG_NORMAL_Y    = 3'd4;
	localparam logic [IDX_W-1:0] REG_NORMAL_Z    = 3'd5;
	localparam logic [IDX_W-1:0] REG_DISK_RADIUS = 3'd6;
	localparam logic [IDX_W-1:0] REG_NEAR_LIMIT  = 3'd7;

	// Three 32-bit coordinates, index 0 is x.
	typedef logic [2:0][31:0] vec3_t;

	// Word carried through the divider stages.
	typedef struct packed {
		logic             kill;
		logic             neg;
		vec3_t            org;
		vec3_t            dir;
		logic [MAG_W-1:0] dm;
		logic [MAG_W-1:0] rem;
		logic [QUO_W-1:0] quo;
		logic [QUO_W-1:0] nbits;
	} div_t;

endpackage

[rtl/rdi_ifs.sv]
// Valid/ready channel interfaces for rays in and hit results out.
// Depends on nothing; used by the top level ray_disk_intersection.
interface rdi_ray_if;
	logic        valid;
	logic        ready;
	logic [31:0] origin_x;
	logic [31:0] origin_y;
	logic [31:0] origin_z;
	logic [31:0] dir_x;
	logic [31:0] dir_y;
	logic [31:0] dir_z;

	modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		input ready);
	modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
		output ready);
endinterface

interface rdi_hit_if;
	logic        valid;
	logic        ready;
	logic        is_hit;
	logic [31:0] hit_distance;
	logic [31:0] hit_point_x;
	logic [31:0] hit_point_y;
	logic [31:0] hit_point_z;

	modport source (output valid, is_hit, hit_distance, hit_point_x, hit_point_y,
		hit_point_z, input ready);
	modport sink (input valid, is_hit, hit_distance, hit_point_x, hit_point_y,
		hit_point_z, output ready);
endinterface

[rtl/rdi_div.sv]
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on rdi_pkg and ray_disk_intersection_defines.svh.
`include "ray_disk_intersection_defines.svh"

module rdi_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  rdi_pkg::div_t in_data,
	output logic         in_ready,
	output logic         out_valid,
	output rdi_pkg::div_t out_data,
	input  logic         out_ready
);

	localparam int N = rdi_pkg::QUO_W;

	rdi_pkg::div_t div_s [1:N];
	logic          vld_s [1:N];
	logic          adv   [1:N+1];

	assign adv[N+1]  = out_ready;
	assign in_ready  = adv[1];
	assign out_valid = vld_s[N];
	assign out_data  = div_s[N];

	for (genvar k = 1; k <= N; k++) begin : g_stage
		rdi_pkg::div_t prev_d;
		logic          prev_v;
		rdi_pkg::div_t nxt;
		logic [rdi_pkg::MAG_W:0] rem2;
		logic [rdi_pkg::MAG_W:0] diff;
		logic                    ge;

		if (k == 1) begin : g_first
			assign prev_d = in_data;
			assign prev_v = in_valid;
		end else begin : g_rest
			assign prev_d = div_s[k-1];
			assign prev_v = vld_s[k-1];
		end

		// A stage takes a new word when it is empty or its word moves on.
		assign adv[k] = !vld_s[k] || adv[k+1];

		// Shift in the next dividend bit and subtract when the divisor fits.
		always_comb begin
			rem2     = {prev_d.rem, prev_d.nbits[N-1]};
			diff     = rem2 - {1'b0, prev_d.dm};
			ge       = rem2 >= {1'b0, prev_d.dm};
			nxt      = prev_d;
			nxt.rem  = ge ? diff[rdi_pkg::MAG_W-1:0] : rem2[rdi_pkg::MAG_W-1:0];
			nxt.quo  = {prev_d.quo[N-2:0], ge};
			nxt.nbits = {prev_d.nbits[N-2:0], 1'b0};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_s[k] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k] && prev_v) begin
				div_s[k] <= nxt;
			end
		end
	end

	// The remainder always ends below the divisor for a live word.
	`RDI_ASSERT_IMPL(a_rem_below, clk, arst_n, out_valid && !out_data.kill, out_data.rem < out_data.dm)
	// A stalled result word stays put.
	`RDI_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	// An empty first stage always takes a word.
	`RDI_ASSERT_IMPL(a_first_open, clk, arst_n, !vld_s[1], in_ready)

endmodule

[rtl/ray_disk_intersection.sv]
// Top level of the ray against disk intersection pipeline.
// Depends on rdi_pkg, rdi_ifs.sv, rdi_div and ray_disk_intersection_defines.svh.
//
//  Port      | Dir | Handshake      | Word
//  ray_in    | in  | valid/ready    | ray origin and direction, Q16.16
//  hit_out   | out | valid/ready    | hit flag, t and hit point, Q16.16
//  cfg_*     | in  | write enable   | disk registers by index, no read-back
//
// One ray is accepted per cycle unless hit_out stalls; each passes 39 register
// stages before its result is offered on hit_out.
// Most stages are in the divider, which resolves one quotient bit per stage.
// Every stage has its own valid bit; a stage refills as soon as it empties, so
// bubbles close up under a stall and no word is lost or repeated.
// Reset clears all valid bits and loads the disk registers with their defaults.
`include "ray_disk_intersection_defines.svh"

module ray_disk_intersection (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rdi_pkg::IDX_W-1:0]        cfg_idx,
	input  logic [31:0]                      cfg_data,
	rdi_ray_if.sink                          ray_in,
	rdi_hit_if.source                        hit_out
);

	// Disk registers.
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic signed [17:0] nx_q, ny_q, nz_q;
	logic [30:0]        radius_q;
	logic [15:0]        eps_q;
	logic [61:0]        rsq_q;
	logic signed [31:0] ctr [3];
	logic signed [17:0] nrm [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			cz_q     <= '0;
			nx_q     <= '0;
			ny_q     <= '0;
			nz_q     <= 18'sd65536;
			radius_q <= 31'd65536;
			eps_q    <= 16'd7;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				rdi_pkg::REG_CENTER_X:    cx_q     <= cfg_data;
				rdi_pkg::REG_CENTER_Y:    cy_q     <= cfg_data;
				rdi_pkg::REG_CENTER_Z:    cz_q     <= cfg_data;
				rdi_pkg::REG_NORMAL_X:    nx_q     <= cfg_data[17:0];
				rdi_pkg::REG_NORMAL_Y:    ny_q     <= cfg_data[17:0];
				rdi_pkg::REG_NORMAL_Z:    nz_q     <= cfg_data[17:0];
				rdi_pkg::REG_DISK_RADIUS: radius_q <= cfg_data[30:0];
				rdi_pkg::REG_NEAR_LIMIT:  eps_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Squared radius is registered from the radius register in the next cycle.
	always_ff @(posedge clk) begin
		rsq_q <= radius_q * radius_q;
	end

	assign ctr[0] = cx_q;
	assign ctr[1] = cy_q;
	assign ctr[2] = cz_q;
	assign nrm[0] = nx_q;
	assign nrm[1] = ny_q;
	assign nrm[2] = nz_q;

	// Stage valid bits and the ready chain.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8;
	logic div_rdy, dv;
	rdi_pkg::div_t dq;

	assign adv8 = !v_s8 || hit_out.ready;
	assign adv7 = !v_s7 || adv8;
	assign adv6 = !v_s6 || adv7;
	assign adv5 = !v_s5 || adv6;
	assign adv4 = !v_s4 || adv5;
	assign adv3 = !v_s3 || div_rdy;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign ray_in.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= ray_in.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= dv;
			if (adv5) v_s5 <= v_s4;
			if (adv6) v_s6 <= v_s5;
			if (adv7) v_s7 <= v_s6;
			if (adv8) v_s8 <= v_s7;
		end
	end

	// Stage 1: per-axis products of the two dot products.
	rdi_pkg::vec3_t     org_in, dir_in;
	logic signed [32:0] dif [3];
	logic signed [50:0] nump [3];
	logic signed [49:0] denp [3];
	logic signed [50:0] nump_s1 [3];
	logic signed [49:0] denp_s1 [3];
	rdi_pkg::vec3_t     org_s1, dir_s1;

	always_comb begin
		org_in[0] = ray_in.origin_x;
		org_in[1] = ray_in.origin_y;
		org_in[2] = ray_in.origin_z;
		dir_in[0] = ray_in.dir_x;
		dir_in[1] = ray_in.dir_y;
		dir_in[2] = ray_in.dir_z;
		for (int i = 0; i < 3; i++) begin
			dif[i]  = {ctr[i][31], ctr[i]} - $signed({org_in[i][31], org_in[i]});
			nump[i] = dif[i] * nrm[i];
			denp[i] = $signed(dir_in[i]) * nrm[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && ray_in.valid) begin
			nump_s1 <= nump;
			denp_s1 <= denp;
			org_s1  <= org_in;
			dir_s1  <= dir_in;
		end
	end

	// Stage 2: sum the products into numerator and denominator.
	logic signed [rdi_pkg::SUM_W-1:0] num_s2, den_s2;
	rdi_pkg::vec3_t                   org_s2, dir_s2;

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			num_s2 <= rdi_pkg::SUM_W'(nump_s1[0]) + rdi_pkg::SUM_W'(nump_s1[1])
				+ rdi_pkg::SUM_W'(nump_s1[2]);
			den_s2 <= rdi_pkg::SUM_W'(denp_s1[0]) + rdi_pkg::SUM_W'(denp_s1[1])
				+ rdi_pkg::SUM_W'(denp_s1[2]);
			org_s2 <= org_s1;
			dir_s2 <= dir_s1;
		end
	end

	// Stage 3: magnitudes, sign of t, range check and divider setup.
	logic [rdi_pkg::SUM_W-1:0] nm_w, dm_w;
	logic                      ovf;
	rdi_pkg::div_t             d3, d_s3;

	always_comb begin
		nm_w = num_s2[rdi_pkg::SUM_W-1] ? rdi_pkg::SUM_W'(-num_s2) : num_s2;
		dm_w = den_s2[rdi_pkg::SUM_W-1] ? rdi_pkg::SUM_W'(-den_s2) : den_s2;
		// Integer part of t must stay within 15 bits.
		ovf = {15'd0, nm_w[rdi_pkg::MAG_W-1:0]} >= {dm_w[rdi_pkg::MAG_W-1:0], 15'd0};
		d3.kill  = (den_s2 == '0) || ovf;
		d3.neg   = num_s2[rdi_pkg::SUM_W-1] ^ den_s2[rdi_pkg::SUM_W-1];
		d3.org   = org_s2;
		d3.dir   = dir_s2;
		d3.dm    = dm_w[rdi_pkg::MAG_W-1:0];
		d3.rem   = {15'd0, nm_w[rdi_pkg::MAG_W-1:15]};
		d3.quo   = '0;
		d3.nbits = {nm_w[14:0], 16'd0};
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			d_s3 <= d3;
		end
	end

	rdi_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_data   (d_s3),
		.in_ready  (div_rdy),
		.out_valid (dv),
		.out_data  (dq),
		.out_ready (adv4)
	);

	// Stage 4: near check and the products t times |D|.
	logic [31:0]              dmag [3];
	logic [62:0]              prod [3];
	logic [62:0]              prod_s4 [3];
	logic [2:0]               sgn, sgn_s4;
	logic [rdi_pkg::QUO_W-1:0] tm_s4;
	logic                     neg_s4, kill_s4;
	rdi_pkg::vec3_t           org_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dmag[i] = dq.dir[i][31] ? (~dq.dir[i] + 32'd1) : dq.dir[i];
			prod[i] = dq.quo * dmag[i];
			sgn[i]  = dq.neg ^ dq.dir[i][31];
		end
	end

	always_ff @(posedge clk) begin
		if (adv4 && dv) begin
			prod_s4 <= prod;
			sgn_s4  <= sgn;
			tm_s4   <= dq.quo;
			neg_s4  <= dq.neg;
			kill_s4 <= dq.kill || (dq.quo <= {15'd0, eps_q});
			org_s4  <= dq.org;
		end
	end

	// Stage 5: hit point as origin plus or minus the scaled direction, size check and signed t.
	logic [46:0]        pr [3];
	logic signed [48:0] pt [3];
	logic signed [48:0] pt_s5 [3];
	logic               big;
	logic               kill_s5;
	logic [31:0]        t_s5;

	always_comb begin
		big = 1'b0;
		for (int i = 0; i < 3; i++) begin
			pr[i] = prod_s4[i][62:rdi_pkg::FRAC_BITS];
			big   = big || (pr[i] > 47'd1099511627776);
			pt[i] = sgn_s4[i]
				? $signed({{17{org_s4[i][31]}}, org_s4[i]}) - $signed({2'b00, pr[i]})
				: $signed({{17{org_s4[i][31]}}, org_s4[i]}) + $signed({2'b00, pr[i]});
		end
	end

	always_ff @(posedge clk) begin
		if (adv5 && v_s4) begin
			pt_s5   <= pt;
			kill_s5 <= kill_s4 || big;
			t_s5    <= neg_s4 ? (~{1'b0, tm_s4} + 32'd1) : {1'b0, tm_s4};
		end
	end

	// Stage 6: range check of the hit point and offsets from the center.
	logic signed [32:0] ev [3];
	logic [32:0]        em [3];
	logic               bad;
	logic [30:0]        em_s6 [3];
	rdi_pkg::vec3_t     pt_s6;
	logic               kill_s6;
	logic [31:0]        t_s6;

	always_comb begin
		bad = 1'b0;
		for (int i = 0; i < 3; i++) begin
			bad   = bad || !((&pt_s5[i][48:31]) || !(|pt_s5[i][48:31]));
			ev[i] = $signed({pt_s5[i][31], pt_s5[i][31:0]}) - {ctr[i][31], ctr[i]};
			em[i] = ev[i][32] ? 33'(-ev[i]) : ev[i];
			bad   = bad || (|em[i][32:31]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv6 && v_s5) begin
			for (int i = 0; i < 3; i++) begin
				em_s6[i] <= em[i][30:0];
				pt_s6[i] <= pt_s5[i][31:0];
			end
			kill_s6 <= kill_s5 || bad;
			t_s6    <= t_s5;
		end
	end

	// Stage 7: squared offsets.
	logic [61:0]    sq_s7 [3];
	rdi_pkg::vec3_t pt_s7;
	logic           kill_s7;
	logic [31:0]    t_s7;

	always_ff @(posedge clk) begin
		if (adv7 && v_s6) begin
			for (int i = 0; i < 3; i++) begin
				sq_s7[i] <= em_s6[i] * em_s6[i];
			end
			pt_s7   <= pt_s6;
			kill_s7 <= kill_s6;
			t_s7    <= t_s6;
		end
	end

	// Stage 8: compare against the squared radius into the output register.
	logic [63:0]    dist2;
	logic           hit_w;
	logic           hit_s8;
	logic [31:0]    t_s8;
	rdi_pkg::vec3_t pt_s8;

	always_comb begin
		dist2 = 64'(sq_s7[0]) + 64'(sq_s7[1]) + 64'(sq_s7[2]);
		hit_w = !kill_s7 && (dist2 < {2'b00, rsq_q});
	end

	always_ff @(posedge clk) begin
		if (adv8 && v_s7) begin
			hit_s8 <= hit_w;
			t_s8   <= hit_w ? t_s7 : '0;
			pt_s8  <= hit_w ? pt_s7 : '0;
		end
	end

	assign hit_out.valid        = v_s8;
	assign hit_out.is_hit       = hit_s8;
	assign hit_out.hit_distance = t_s8;
	assign hit_out.hit_point_x  = pt_s8[0];
	assign hit_out.hit_point_y  = pt_s8[1];
	assign hit_out.hit_point_z  = pt_s8[2];

	// A miss carries an all-zero word.
	`RDI_ASSERT_IMPL(a_miss_zero, clk, arst_n, hit_out.valid && !hit_out.is_hit, (hit_out.hit_distance == 32'd0) && (hit_out.hit_point_x == 32'd0) && (hit_out.hit_point_y == 32'd0) && (hit_out.hit_point_z == 32'd0))
	// A hit never has t at zero, since the near limit rejects it.
	`RDI_ASSERT_IMPL(a_hit_t_nonzero, clk, arst_n, hit_out.valid && hit_out.is_hit, hit_out.hit_distance != 32'd0)
	// The word waiting for the divider holds while the divider is full.
	`RDI_ASSERT_NEXT(a_s3_hold, clk, arst_n, v_s3 && !div_rdy, v_s3 && $stable(d_s3))

endmodule
